// ===== hw/rtl/va_pkg.sv =====
// Shared types, widths and the arctangent table for the vector angle core.
// Used by va_rotator, vector_angle_core, va_checker and the testbench; depends on nothing else.

package va_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ACC_WIDTH   = 32;
    localparam int STEPS       = 32;
    localparam int STEP_WIDTH  = $clog2(STEPS);
    localparam int NORM_EXP    = 40;
    localparam int DP_WIDTH    = NORM_EXP + 6;
    localparam int SHIFT_WIDTH = $clog2(NORM_EXP + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    localparam logic [ACC_WIDTH-1:0] ACC_HALF_TURN = ACC_WIDTH'(1) << (ACC_WIDTH - 1);
    localparam logic [ACC_WIDTH-1:0] ROUND_HALF =
        (ACC_WIDTH'(1) << (ACC_WIDTH - ANGLE_WIDTH)) >> 1;

    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    typedef struct packed {
        logic                       valid;
        logic                       spec;
        logic [1:0]                 quad;
        logic [DP_WIDTH-1:0]        x;
        logic [DP_WIDTH-1:0]        y;
        logic [ACC_WIDTH-1:0]       acc;
    } rot_word_t;

    function automatic logic [ACC_WIDTH-1:0] atan_turn(input logic [STEP_WIDTH-1:0] idx);
        logic [ACC_WIDTH-1:0] val;
        unique case (idx)
            5'd0:  val = 32'd536870912;
            5'd1:  val = 32'd316933406;
            5'd2:  val = 32'd167458907;
            5'd3:  val = 32'd85004756;
            5'd4:  val = 32'd42667331;
            5'd5:  val = 32'd21354465;
            5'd6:  val = 32'd10679838;
            5'd7:  val = 32'd5340245;
            5'd8:  val = 32'd2670163;
            5'd9:  val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            5'd24: val = 32'd41;
            5'd25: val = 32'd20;
            5'd26: val = 32'd10;
            5'd27: val = 32'd5;
            5'd28: val = 32'd3;
            5'd29: val = 32'd1;
            5'd30: val = 32'd1;
            5'd31: val = 32'd0;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/va_rotator.sv =====
// Pipelined CORDIC vectoring array, one iteration per register stage.
// Depends on va_pkg for widths, the stage word type and the arctangent table.

module va_rotator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  va_pkg::rot_word_t rot_in,
    output va_pkg::rot_word_t rot_out
);

    logic [va_pkg::STEPS:0]                   valid_reg;
    logic [va_pkg::STEPS:0]                   spec_reg;
    logic [1:0]                               quad_reg [va_pkg::STEPS+1];
    logic signed [va_pkg::DP_WIDTH-1:0]       x_reg    [va_pkg::STEPS+1];
    logic signed [va_pkg::DP_WIDTH-1:0]       y_reg    [va_pkg::STEPS+1];
    logic [va_pkg::ACC_WIDTH-1:0]             acc_reg  [va_pkg::STEPS+1];
    logic signed [va_pkg::DP_WIDTH-1:0]       x_next   [va_pkg::STEPS];
    logic signed [va_pkg::DP_WIDTH-1:0]       y_next   [va_pkg::STEPS];
    logic [va_pkg::ACC_WIDTH-1:0]             acc_next [va_pkg::STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[va_pkg::STEPS-1:0], rot_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spec_reg[0] <= rot_in.spec;
            quad_reg[0] <= rot_in.quad;
            x_reg[0]    <= $signed(rot_in.x);
            y_reg[0]    <= $signed(rot_in.y);
            acc_reg[0]  <= rot_in.acc;
        end
    end

    for (genvar i = 0; i < va_pkg::STEPS; i++)
    begin : g_step
        logic signed [va_pkg::DP_WIDTH-1:0] sx;
        logic signed [va_pkg::DP_WIDTH-1:0] sy;

        assign sx = x_reg[i] >>> i;
        assign sy = y_reg[i] >>> i;

        always_comb
        begin
            if (!y_reg[i][va_pkg::DP_WIDTH-1])
            begin
                x_next[i]   = x_reg[i] + sy;
                y_next[i]   = y_reg[i] - sx;
                acc_next[i] = acc_reg[i] + va_pkg::atan_turn(va_pkg::STEP_WIDTH'(i));
            end
            else
            begin
                x_next[i]   = x_reg[i] - sy;
                y_next[i]   = y_reg[i] + sx;
                acc_next[i] = acc_reg[i] - va_pkg::atan_turn(va_pkg::STEP_WIDTH'(i));
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                spec_reg[i+1] <= spec_reg[i];
                quad_reg[i+1] <= quad_reg[i];
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                acc_reg[i+1]  <= acc_next[i];
            end
        end
    end

    assign rot_out.valid = valid_reg[va_pkg::STEPS];
    assign rot_out.spec  = spec_reg[va_pkg::STEPS];
    assign rot_out.quad  = quad_reg[va_pkg::STEPS];
    assign rot_out.x     = x_reg[va_pkg::STEPS];
    assign rot_out.y     = y_reg[va_pkg::STEPS];
    assign rot_out.acc   = acc_reg[va_pkg::STEPS];

endmodule

// ===== hw/rtl/vector_angle_core.sv =====
// Top level of the vector angle core: normalisation, CORDIC array and output queue.
// Depends on va_pkg and va_rotator.
//
//   channel | signals                         | word
//   input   | in_valid, in_stall              | x_coord, y_coord (signed Q8.8)
//   output  | out_valid, out_stall            | angle (65536 is one full turn)
//
// One word is accepted every cycle while in_stall is low; a result passes through
// three normalisation stages, 32 CORDIC stages and the output queue.
// Reset clears all valid bits and empties the two-entry output queue.
// A stalled output fills the queue; in_stall rises only when both entries are full,
// and the whole pipeline then holds until a result is taken.

module vector_angle_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [va_pkg::COORD_WIDTH-1:0] x_coord,
    input  logic signed [va_pkg::COORD_WIDTH-1:0] y_coord,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [va_pkg::ANGLE_WIDTH-1:0]      angle
);

    localparam int CW = va_pkg::COORD_WIDTH;

    logic                          adv;
    logic                          push;
    logic                          pop;
    logic [va_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [va_pkg::COUNT_WIDTH-1:0] count_next;
    logic [va_pkg::ANGLE_WIDTH-1:0] head_reg;
    logic [va_pkg::ANGLE_WIDTH-1:0] tail_reg;
    logic [va_pkg::ANGLE_WIDTH-1:0] result;

    logic signed [CW:0]            xw;
    logic signed [CW:0]            yw;
    logic signed [CW:0]            x1_next;
    logic signed [CW:0]            y1_next;
    logic [CW:0]                   ay_next;
    logic                          spec_next;
    logic [1:0]                    quad_next;

    logic                          valid_s1_reg;
    logic signed [CW:0]            x1_s1_reg;
    logic signed [CW:0]            y1_s1_reg;
    logic [CW:0]                   ay_s1_reg;
    logic                          half_s1_reg;
    logic                          spec_s1_reg;
    logic [1:0]                    quad_s1_reg;

    logic [CW:0]                   mag;
    logic [va_pkg::SHIFT_WIDTH-1:0] msb;
    logic [va_pkg::SHIFT_WIDTH-1:0] k_next;

    logic                          valid_s2_reg;
    logic signed [CW:0]            x1_s2_reg;
    logic signed [CW:0]            y1_s2_reg;
    logic                          half_s2_reg;
    logic                          spec_s2_reg;
    logic [1:0]                    quad_s2_reg;
    logic [va_pkg::SHIFT_WIDTH-1:0] k_s2_reg;

    logic signed [va_pkg::DP_WIDTH-1:0] xe;
    logic signed [va_pkg::DP_WIDTH-1:0] ye;
    va_pkg::rot_word_t             rot_in;
    va_pkg::rot_word_t             rot_out;
    logic [va_pkg::ACC_WIDTH-1:0]  turn;
    logic [va_pkg::ACC_WIDTH:0]    rounded;

    assign adv      = (count_reg != va_pkg::COUNT_WIDTH'(va_pkg::FIFO_DEPTH));
    assign in_stall = !adv;

    // Fold the left half-plane onto the right one and classify exact axes.
    always_comb
    begin
        xw      = {x_coord[CW-1], x_coord};
        yw      = {y_coord[CW-1], y_coord};
        x1_next = xw[CW] ? -xw : xw;
        y1_next = xw[CW] ? -yw : yw;
        ay_next = yw[CW] ? $unsigned(-yw) : $unsigned(yw);
        spec_next = (xw == '0) || (yw == '0);
        priority if (yw == '0)
        begin
            quad_next = xw[CW] ? va_pkg::QUAD_WEST : va_pkg::QUAD_EAST;
        end
        else
        begin
            quad_next = yw[CW] ? va_pkg::QUAD_SOUTH : va_pkg::QUAD_NORTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_s1_reg <= in_valid;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_s1_reg   <= x1_next;
            y1_s1_reg   <= y1_next;
            ay_s1_reg   <= ay_next;
            half_s1_reg <= xw[CW];
            spec_s1_reg <= spec_next;
            quad_s1_reg <= quad_next;
        end
    end

    // The shift brings the larger magnitude into the range from 2^40 up to 2^41.
    always_comb
    begin
        mag = ($unsigned(x1_s1_reg) > ay_s1_reg) ? $unsigned(x1_s1_reg) : ay_s1_reg;
        msb = '0;
        for (int b = 0; b <= CW; b++)
        begin
            if (mag[b])
            begin
                msb = va_pkg::SHIFT_WIDTH'(b);
            end
        end
        k_next = va_pkg::SHIFT_WIDTH'(va_pkg::NORM_EXP) - msb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_s2_reg   <= x1_s1_reg;
            y1_s2_reg   <= y1_s1_reg;
            half_s2_reg <= half_s1_reg;
            spec_s2_reg <= spec_s1_reg;
            quad_s2_reg <= quad_s1_reg;
            k_s2_reg    <= k_next;
        end
    end

    always_comb
    begin
        xe = {{(va_pkg::DP_WIDTH - CW - 1){x1_s2_reg[CW]}}, x1_s2_reg};
        ye = {{(va_pkg::DP_WIDTH - CW - 1){y1_s2_reg[CW]}}, y1_s2_reg};
        rot_in.valid = valid_s2_reg;
        rot_in.spec  = spec_s2_reg;
        rot_in.quad  = quad_s2_reg;
        rot_in.x     = xe <<< k_s2_reg;
        rot_in.y     = ye <<< k_s2_reg;
        rot_in.acc   = half_s2_reg ? va_pkg::ACC_HALF_TURN : '0;
    end

    va_rotator u_rotator (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rot_in  (rot_in),
        .rot_out (rot_out)
    );

    always_comb
    begin
        turn    = rot_out.spec ? {rot_out.quad, (va_pkg::ACC_WIDTH - 2)'(0)} : rot_out.acc;
        rounded = {1'b0, turn} + {1'b0, va_pkg::ROUND_HALF};
        result  = rounded[va_pkg::ACC_WIDTH-1 -: va_pkg::ANGLE_WIDTH];
    end

    assign push = adv && rot_out.valid;
    assign pop  = (count_reg != '0) && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + va_pkg::COUNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - va_pkg::COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (push && ((count_reg == '0) || pop))
        begin
            head_reg <= result;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
        else
        begin
            head_reg <= head_reg;
        end
        if (push && (count_reg != '0) && !pop)
        begin
            tail_reg <= result;
        end
    end

    assign out_valid = (count_reg != '0);
    assign angle     = head_reg;

endmodule

// ===== hw/rtl/va_checker.sv =====
// Port-level checks for vector_angle_core, attached by the bind statement below.
// Depends on va_pkg for the port widths.

module va_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic signed [va_pkg::COORD_WIDTH-1:0] x_coord,
    input logic signed [va_pkg::COORD_WIDTH-1:0] y_coord,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [va_pkg::ANGLE_WIDTH-1:0]      angle
);

    logic in_seen;

    assign in_seen = in_valid || (x_coord == '0) || (y_coord == '0) || !in_valid;

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("stalled output word changed");

    // With nothing waiting at the output the input is never held off.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        in_seen && !out_valid |-> !in_stall)
        else $error("input stalled with an empty output queue");

    // The input can only become stalled after the output was held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without a held output word");

    // Taking a result from a full queue frees the input in the next cycle.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input stall persisted after a result was taken");

endmodule

bind vector_angle_core va_checker u_va_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);

// ===== tb/tb_vector_angle_core.sv =====
// Self-checking testbench for vector_angle_core: directed and random vectors with
// random idling on both channels, checked against a bit-exact CORDIC predictor.
// Depends on va_pkg and the vector_angle_core RTL.

module tb_vector_angle_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = va_pkg::COORD_WIDTH;
    localparam int AW         = va_pkg::ANGLE_WIDTH;
    localparam int LATENCY    = 36;
    localparam int N_DIRECTED = 23;
    localparam int N_BLOCKS   = 17;
    localparam int BLOCK_SIZE = 100;
    localparam int HOLD_LEN   = 150;

    localparam int DIR_X [N_DIRECTED] = '{
        0, 256, -256, 0, 0, 32767, -32768, 0, 0, 32767, -32768, 32767,
        -32768, 1, -1, 1, -1, 32767, 32767, -32768, -32768, 1, -1};
    localparam int DIR_Y [N_DIRECTED] = '{
        0, 0, 0, 256, -256, 0, 0, 32767, -32768, 32767, -32768, -32768,
        32767, 1, -1, -1, 1, -1, 1, 1, -1, 32767, -32768};
    localparam int EDGE_VALUES [6] = '{-32768, -32767, -1, 0, 1, 32767};

    class angle_scoreboard;
        typedef struct {
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic [AW-1:0]        angle;
        } angle_entry_t;

        logic [31:0] atan_steps [32] = '{
            32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
            32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304,
            32'd652, 32'd326, 32'd163, 32'd81,
            32'd41, 32'd20, 32'd10, 32'd5,
            32'd3, 32'd1, 32'd1, 32'd0};

        angle_entry_t expected_angles [$];
        int           mismatches = 0;
        int           checked = 0;

        function logic [AW-1:0] round_turn(logic [31:0] acc);
            logic [32:0] t;
            t = {1'b0, acc} + ((33'd1 << (32 - AW)) >> 1);
            return t[31 -: AW];
        endfunction

        function logic [AW-1:0] predict_angle(logic signed [CW-1:0] xc,
                                              logic signed [CW-1:0] yc);
            longint      x;
            longint      y;
            longint      sx;
            longint      sy;
            longint      limit;
            logic [31:0] acc;
            x     = longint'(xc);
            y     = longint'(yc);
            limit = 64'sd1 <<< 40;
            acc   = '0;
            if (x == 0 && y == 0)
                return '0;
            if (y == 0)
                return round_turn(x > 0 ? 32'h0000_0000 : 32'h8000_0000);
            if (x == 0)
                return round_turn(y > 0 ? 32'h4000_0000 : 32'hC000_0000);
            while ((x < 0 ? -x : x) < limit && (y < 0 ? -y : y) < limit)
            begin
                x = x * 2;
                y = y * 2;
            end
            if (x < 0)
            begin
                x   = -x;
                y   = -y;
                acc = 32'h8000_0000;
            end
            for (int i = 0; i < 32; i++)
            begin
                sx = x >>> i;
                sy = y >>> i;
                if (y >= 0)
                begin
                    x   = x + sy;
                    y   = y - sx;
                    acc = acc + atan_steps[i];
                end
                else
                begin
                    x   = x - sy;
                    y   = y + sx;
                    acc = acc - atan_steps[i];
                end
            end
            return round_turn(acc);
        endfunction

        function void note_vector(logic signed [CW-1:0] xc, logic signed [CW-1:0] yc);
            angle_entry_t e;
            e.x     = xc;
            e.y     = yc;
            e.angle = predict_angle(xc, yc);
            expected_angles.push_back(e);
        endfunction

        function void check_angle(logic [AW-1:0] actual);
            angle_entry_t e;
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual angle %0d",
                         $time, actual);
            end
            else
            begin
                e = expected_angles.pop_front();
                checked++;
                if (actual !== e.angle)
                begin
                    mismatches++;
                    $display("%0t: angle of (%0d, %0d) expected %0d, actual %0d",
                             $time, e.x, e.y, e.angle, actual);
                end
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] x_coord;
    logic signed [CW-1:0] y_coord;
    logic                 out_valid;
    logic                 out_stall;
    logic [AW-1:0]        angle;

    angle_scoreboard board;
    int              hold_asked;
    logic            quiet_rx;
    int              vectors_sent;

    vector_angle_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_vector(input logic signed [CW-1:0] xv,
                               input logic signed [CW-1:0] yv);
        in_valid <= 1'b1;
        x_coord  <= xv;
        y_coord  <= yv;
        do
            @(posedge clk);
        while (in_stall);
        board.note_vector(xv, yv);
        vectors_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic random_vector(output logic signed [CW-1:0] xv,
                                 output logic signed [CW-1:0] yv);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            xv = CW'($urandom);
            yv = CW'($urandom);
        end
        else if (mode <= 7)
        begin
            xv = CW'(int'($urandom_range(0, 16)) - 8);
            yv = CW'(int'($urandom_range(0, 16)) - 8);
        end
        else if (mode == 8)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                xv = CW'($urandom);
                yv = CW'(int'($urandom_range(0, 4)) - 2);
            end
            else
            begin
                xv = CW'(int'($urandom_range(0, 4)) - 2);
                yv = CW'($urandom);
            end
        end
        else
        begin
            xv = CW'(EDGE_VALUES[$urandom_range(0, 5)]);
            yv = CW'(EDGE_VALUES[$urandom_range(0, 5)]);
        end
    endtask

    initial
    begin
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        logic                 gapless;
        in_valid     = 1'b0;
        x_coord      = '0;
        y_coord      = '0;
        rst_n        = 1'b0;
        hold_asked   = 0;
        quiet_rx     = 1'b0;
        vectors_sent = 0;
        board        = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_vector(CW'(DIR_X[i]), CW'(DIR_Y[i]));
            idle_cycles(pick_gap());
        end

        for (int blk = 0; blk < N_BLOCKS; blk++)
        begin
            gapless = (blk % 3 == 1);
            quiet_rx <= (blk % 4 == 2);
            if (blk == 3)
            begin
                gapless = 1'b1;
                hold_asked <= hold_asked + 1;
            end
            for (int i = 0; i < BLOCK_SIZE; i++)
            begin
                random_vector(xv, yv);
                send_vector(xv, yv);
                idle_cycles(gapless ? 0 : pick_gap());
            end
        end
        in_valid <= 1'b0;
        quiet_rx <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("Sent %0d vectors: zero, axes, extremes, near-wrap and random cases.",
                 vectors_sent);
        $display("Checked %0d angles under input and output stalls, %0d mismatches.",
                 board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int hold_done;
        int hold_left;
        int run_left;
        int r;
        hold_done = 0;
        hold_left = 0;
        run_left  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_angle(angle);
            if (hold_asked != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet_rx)
                out_stall <= 1'b0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(1, 30);
                end
                else if (r < 9)
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("%0t: run timed out with %0d angles outstanding", $time, board.pending());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/va_pkg.sv
hw/rtl/va_rotator.sv
hw/rtl/vector_angle_core.sv
hw/rtl/va_checker.sv
tb/tb_vector_angle_core.sv
